FILE: src/artdmx_packet_receiver_top_defines.svh
// Assertion macros for the ArtDMX receiver
`ifndef ARTDMX_PACKET_RECEIVER_TOP_DEFINES_SVH
`define ARTDMX_PACKET_RECEIVER_TOP_DEFINES_SVH
`define ADMX_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ADMX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: src/admx_pkg.sv
// ----------------------------------------------------------------------------
// admx_pkg
// Types and constants shared by the ArtDMX receiver modules.
// ----------------------------------------------------------------------------
package admx_pkg;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_DMX     = 2'd1;
   localparam logic [1:0] ST_POLL    = 2'd2;
   localparam logic [1:0] ST_DISCARD = 2'd3;

   localparam logic [1:0] REG_DMX_OPCODE  = 2'd0;
   localparam logic [1:0] REG_POLL_OPCODE = 2'd1;
   localparam logic [1:0] REG_RATE_WINDOW = 2'd2;

   localparam int unsigned MAX_DATA   = 512;
   localparam int unsigned DATA_START = 18;
   localparam int unsigned MIN_PACKET = 12;
   localparam int unsigned POS_W      = 11;
   localparam int unsigned LEN_W      = 10;

   localparam logic [63:0] ART_IDENT = 64'h00_74_65_4E_2D_74_72_41;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       end_of_packet;
      logic [8:0] channel;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_value;
      logic [31:0] packet_total;
      logic [31:0] packet_rate;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_COPY,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic start_read;
      logic read_done;
      logic judge;
      logic copy_step;
      logic copy_end;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_byte;
      logic is_read;
      logic need_copy;
      logic copy_last;
   } dp_sts_type;

endpackage

FILE: src/admx_ctrl.sv
// ----------------------------------------------------------------------------
// admx_ctrl
// Sequencer: accepts a request, steps the datapath, presents the result.
// ----------------------------------------------------------------------------
module admx_ctrl import admx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.is_read) state_in = S_READ;
            else if (sts.need_copy) state_in = S_COPY;
            else state_in = S_RESP;
         end
         S_READ: state_in = S_RESP;
         S_COPY: begin
            if (sts.copy_last) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.take = req_valid;
         end
         S_EXEC: begin
            cmd.judge = 1'b1;
            cmd.start_read = sts.is_read;
            cmd.load_rsp = !sts.is_read && !sts.need_copy;
         end
         S_READ: begin
            cmd.read_done = 1'b1;
            cmd.load_rsp = 1'b1;
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            cmd.copy_end = sts.copy_last;
            cmd.load_rsp = sts.copy_last;
         end
         S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: src/admx_datapath.sv
// ----------------------------------------------------------------------------
// admx_datapath
// Packet parser, staging and live level memories, counters.
// ----------------------------------------------------------------------------
module admx_datapath import admx_pkg::*; #(
   parameter int unsigned CHANNELS    = 512,
   parameter int unsigned MAX_PAYLOAD = 600
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  logic [15:0]     dmx_opcode,
   input  logic [15:0]     poll_opcode,
   input  logic [15:0]     rate_window_ms,
   input  dp_cmd_type      cmd,
   output dp_sts_type      sts,
   output rsp_payload_type rsp_payload
);

   localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Live levels: commits always cover a prefix of the channels, so a
   // high-water mark tells written entries from ones still at reset zero.
   logic [7:0] live_mem [CHANNELS];
   logic [7:0] stage_mem [CHANNELS];
   logic [LEN_W-1:0] fill_ff;

   req_payload_type     item_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                hdr_ok_ff;
   logic [15:0]         opc_ff;
   logic [15:0]         len_ff;
   logic [31:0]         total_ff, wcount_ff, rate_ff;
   logic [15:0]         wms_ff;
   logic [1:0]          status_ff;
   logic [LEN_W-1:0]    copy_len_ff;
   logic [LEN_W-1:0]    copy_idx_ff;
   logic [7:0]          stage_rd_ff;
   logic [7:0]          live_rd_ff;
   logic                rd_in_range_ff;
   logic                rd_vld_ff;
   rsp_payload_type     rsp_ff;

   logic                is_byte, is_read, is_tick, eop;
   logic [POS_W-1:0]    pos;
   logic                in_payload;
   logic [POS_W-1:0]    n_in;
   logic                hdr_in;
   logic [15:0]         opc_in, len_in;
   logic [LEN_W-1:0]    len_clip;
   logic [LEN_W-1:0]    keep_len;
   logic                is_dmx, dmx_ok;
   logic [1:0]          judge_st;
   logic [16:0]         wms_next;
   logic [16:0]         limit;
   logic [CH_W-1:0]     wr_idx;
   logic                do_stage;
   logic                stage_wr;
   logic [POS_W-1:0]    data_off;

   assign is_byte = item_ff.kind == KIND_BYTE;
   assign is_read = item_ff.kind == KIND_READ;
   assign is_tick = item_ff.kind == KIND_TICK;
   assign eop     = item_ff.end_of_packet;
   assign pos     = pos_ff;
   assign in_payload = pos < POS_W'(MAX_PAYLOAD);
   assign data_off = pos - POS_W'(DATA_START);

   // parser: header fields
   always_comb begin
      hdr_in = hdr_ok_ff;
      opc_in = opc_ff;
      len_in = len_ff;
      do_stage = 1'b0;
      if (in_payload) begin
         if (pos < POS_W'(8)) begin
            if (item_ff.data_byte != ART_IDENT[pos[2:0]*8 +: 8]) hdr_in = 1'b0;
         end else if (pos == POS_W'(8)) begin
            opc_in[7:0] = item_ff.data_byte;
         end else if (pos == POS_W'(9)) begin
            opc_in[15:8] = item_ff.data_byte;
         end else if (pos == POS_W'(16)) begin
            len_in[15:8] = item_ff.data_byte;
         end else if (pos == POS_W'(17)) begin
            len_in[7:0] = item_ff.data_byte;
         end else if (pos >= POS_W'(DATA_START) && data_off < POS_W'(CHANNELS)) begin
            do_stage = 1'b1;
         end
      end
   end

   assign n_in     = in_payload ? pos + POS_W'(1) : pos;
   assign len_clip = (len_in > 16'(MAX_DATA)) ? LEN_W'(MAX_DATA) : len_in[LEN_W-1:0];
   assign keep_len = (len_clip > LEN_W'(CHANNELS)) ? LEN_W'(CHANNELS) : len_clip;
   assign is_dmx   = opc_in == dmx_opcode && n_in >= POS_W'(DATA_START);
   assign dmx_ok   = n_in >= POS_W'(DATA_START) + POS_W'(len_clip);
   assign wr_idx   = data_off[CH_W-1:0];
   assign stage_wr = cmd.judge && is_byte && do_stage;

   always_comb begin
      if (n_in < POS_W'(MIN_PACKET) || !hdr_in) judge_st = ST_DISCARD;
      else if (is_dmx) judge_st = dmx_ok ? ST_DMX : ST_DISCARD;
      else if (opc_in == poll_opcode) judge_st = ST_POLL;
      else judge_st = ST_DISCARD;
   end

   assign sts.is_byte   = is_byte;
   assign sts.is_read   = is_read;
   assign sts.need_copy = is_byte && eop && judge_st == ST_DMX && keep_len != '0;
   assign sts.copy_last = copy_idx_ff + LEN_W'(1) >= copy_len_ff;

   assign limit    = (rate_window_ms == 16'd0) ? 17'd1 : {1'b0, rate_window_ms};
   assign wms_next = {1'b0, wms_ff} + 17'd1;

   // request capture and control registers
   always_ff @(posedge clock) begin
      if (cmd.take) item_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hdr_ok_ff   <= 1'b1;
         opc_ff      <= '0;
         len_ff      <= '0;
         total_ff    <= '0;
         wcount_ff   <= '0;
         rate_ff     <= '0;
         wms_ff      <= '0;
         status_ff   <= ST_NONE;
         copy_idx_ff <= '0;
         copy_len_ff <= '0;
      end else begin
         if (cmd.judge) begin
            status_ff <= ST_NONE;
            if (is_byte) begin
               if (eop) begin
                  pos_ff    <= '0;
                  hdr_ok_ff <= 1'b1;
                  opc_ff    <= '0;
                  len_ff    <= '0;
                  status_ff <= judge_st;
                  if (judge_st == ST_DMX) begin
                     total_ff  <= total_ff + 32'd1;
                     wcount_ff <= wcount_ff + 32'd1;
                  end
                  copy_idx_ff <= '0;
                  copy_len_ff <= keep_len;
               end else begin
                  pos_ff    <= n_in;
                  hdr_ok_ff <= hdr_in;
                  opc_ff    <= opc_in;
                  len_ff    <= len_in;
               end
            end else if (is_tick) begin
               if (wms_next >= limit) begin
                  rate_ff   <= wcount_ff;
                  wcount_ff <= '0;
                  wms_ff    <= '0;
               end else begin
                  wms_ff <= wms_next[15:0];
               end
            end
         end
         if (cmd.copy_step) copy_idx_ff <= copy_idx_ff + LEN_W'(1);
      end
   end

   // staging memory: written by parser, read by the commit walk
   always_ff @(posedge clock) begin
      if (stage_wr) stage_mem[wr_idx] <= item_ff.data_byte;
   end

   // Copy pipeline: the staged read for index i is taken the cycle the copy
   // starts (index 0 at judge) and during each copy step for the next index.
   logic [LEN_W-1:0] stage_addr;
   logic [CH_W-1:0]  cp_wr_idx;
   assign stage_addr = cmd.copy_step ? copy_idx_ff + LEN_W'(1) : '0;
   assign cp_wr_idx  = copy_idx_ff[CH_W-1:0];

   // final byte may land on entry 0 in the same cycle the walk reads it
   always_ff @(posedge clock) begin
      if (stage_addr < LEN_W'(CHANNELS)) begin
         if (stage_wr && wr_idx == stage_addr[CH_W-1:0]) begin
            stage_rd_ff <= item_ff.data_byte;
         end else begin
            stage_rd_ff <= stage_mem[stage_addr[CH_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_step) live_mem[cp_wr_idx] <= stage_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.judge && is_byte && eop && judge_st == ST_DMX &&
                   keep_len > fill_ff) begin
         fill_ff <= keep_len;
      end
   end

   // channel read: registered memory read
   logic             rd_in_range;
   logic [CH_W-1:0]  rd_idx;
   assign rd_in_range = 10'(item_ff.channel) < 10'(CHANNELS);
   assign rd_idx      = item_ff.channel[CH_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         live_rd_ff     <= live_mem[rd_idx];
         rd_vld_ff      <= LEN_W'(rd_idx) < fill_ff;
         rd_in_range_ff <= rd_in_range;
      end
   end

   logic [7:0] read_val;
   assign read_val = (cmd.read_done && rd_in_range_ff && rd_vld_ff) ? live_rd_ff : 8'd0;

   // status/counters of this item are settled once load_rsp fires
   logic [1:0]  rsp_status;
   logic [31:0] rsp_total, rsp_rate;
   assign rsp_status = cmd.judge ? ((is_byte && eop) ? judge_st : ST_NONE) : status_ff;
   assign rsp_total  = (cmd.judge && is_byte && eop && judge_st == ST_DMX) ?
                       total_ff + 32'd1 : total_ff;
   assign rsp_rate   = (cmd.judge && is_tick && wms_next >= limit) ? wcount_ff : rate_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status       <= rsp_status;
         rsp_ff.read_value   <= read_val;
         rsp_ff.packet_total <= rsp_total;
         rsp_ff.packet_rate  <= rsp_rate;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: src/admx_csr.sv
// ----------------------------------------------------------------------------
// admx_csr
// Configuration registers behind the register port.
// ----------------------------------------------------------------------------
module admx_csr import admx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] dmx_opcode,
   output logic [15:0] poll_opcode,
   output logic [15:0] rate_window_ms
);

   logic [15:0] dmx_ff, poll_ff, win_ff;
   logic [1:0]  idx;
   logic        wr;

   assign idx = csr_paddr[3:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dmx_ff  <= 16'h5000;
         poll_ff <= 16'h2000;
         win_ff  <= 16'd1000;
      end else if (wr) begin
         case (idx)
            REG_DMX_OPCODE:  dmx_ff  <= csr_pwdata[15:0];
            REG_POLL_OPCODE: poll_ff <= csr_pwdata[15:0];
            REG_RATE_WINDOW: win_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DMX_OPCODE:  csr_prdata = {16'd0, dmx_ff};
         REG_POLL_OPCODE: csr_prdata = {16'd0, poll_ff};
         REG_RATE_WINDOW: csr_prdata = {16'd0, win_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign dmx_opcode     = dmx_ff;
   assign poll_opcode    = poll_ff;
   assign rate_window_ms = win_ff;

endmodule

FILE: src/artdmx_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// artdmx_packet_receiver_top
// ArtDMX receiver: parses payload bytes, commits channel data, counts packets.
// ----------------------------------------------------------------------------
//   channel   direction   handshake
//   req_      in          req_valid / req_stall
//   rsp_      out         rsp_valid / rsp_stall
//   csr_      in/out      APB-style, pready always high
//
// A request passes S_EXEC and then S_RESP for the response handoff; a channel
// read also passes S_READ. A final byte of an accepted DMX packet adds an
// S_COPY walk over each committed channel (up to 512) of the staging memory.
// Reset is synchronous; live levels read as zero until first committed.
// The next request waits until the response has been taken.
`include "artdmx_packet_receiver_top_defines.svh"
module artdmx_packet_receiver_top import admx_pkg::*; #(
   parameter int unsigned CHANNELS    = 512,
   parameter int unsigned MAX_PAYLOAD = 600
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [15:0] dmx_opcode, poll_opcode, rate_window_ms;

   admx_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .dmx_opcode, .poll_opcode,
      .rate_window_ms
   );

   admx_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   admx_datapath #(.CHANNELS(CHANNELS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
      .clock, .reset, .req_payload, .dmx_opcode, .poll_opcode,
      .rate_window_ms, .cmd, .sts, .rsp_payload
   );

   `ADMX_ASSERT_IMPL(a_no_take_while_rsp, clock, reset, rsp_valid, req_stall, "request taken while response pending")
   `ADMX_ASSERT_NEXT(a_take_then_busy, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid, "no work cycle after request")
   `ADMX_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.take, cmd.judge, cmd.copy_step, cmd.read_done}), "overlapping datapath commands")

endmodule
